// File: rtl/afu_pkg.sv
// Shared types, widths, mode codes and threshold generator for the activation unit.
package afu_pkg;

  localparam int unsigned FRAC_BITS_DEF = 8;
  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned ACT_W         = 15;
  localparam int unsigned MAG_W         = 16;

  typedef enum logic [1:0] {
    MODE_RELU          = 2'd0,
    MODE_RELU_DERIV    = 2'd1,
    MODE_SIGMOID       = 2'd2,
    MODE_SIGMOID_DERIV = 2'd3
  } act_mode_t;

  typedef logic [MAG_W-1:0] mag_t;

  // Smallest input magnitude (in LSB steps) at which the rounded sigmoid
  // reaches level 2^(frac_bits-1) + 1 + level_idx. Solves
  // sigmoid(x) >= (2k-1) / 2^(frac_bits+1), i.e. x >= ln(2k-1) - ln(2^(f+1)-2k+1).
  // Evaluated at elaboration only.
  function automatic mag_t sig_threshold(int unsigned frac_bits, int unsigned level_idx);
    real         one_r;
    real         num;
    real         den;
    real         x;
    int unsigned k;
    one_r = 2.0 ** frac_bits;
    k     = (1 << (frac_bits - 1)) + 1 + level_idx;
    num   = real'(2 * k - 1);
    den   = real'((2 << frac_bits) - 2 * k + 1);
    x     = $ceil(one_r * ($ln(num) - $ln(den)));
    if (x > 65535.0) begin
      x = 65535.0;
    end
    if (x < 0.0) begin
      x = 0.0;
    end
    return mag_t'(longint'(x));
  endfunction

endpackage

// File: rtl/activation_function_unit.sv
// Pipelined activation unit: ReLU, ReLU derivative, sigmoid and sigmoid derivative.
//
// One signed fixed-point sample (FRAC_BITS fraction bits) enters per word on
// the in_ channel and one unsigned fixed-point activation leaves per word on
// the out_ channel, in order, with the batch end marker carried alongside.
// The unit accepts a new word every cycle unless out_ready stalls it. At
// the default Q8.8, FRAC_BITS is 8. The pipe is a capture stage, then the
// sigmoid lookup, a binary search over the 2^(FRAC_BITS-1) level thresholds
// of the rounded logistic curve, one threshold bit per stage, followed by a
// level/sign stage, a multiply stage for the derivative and the output
// register. The whole pipe advances together whenever the output register is
// empty or being taken, so a stall on out_ready back-pressures in_ready in
// the same cycle and no word is dropped or duplicated. cfg_write_data selects
// the function (0 relu, 1 relu derivative, 2 sigmoid, 3 sigmoid derivative);
// write it only while the pipe is empty. The threshold tables are constants
// built at elaboration, so there is no table load and no start-up delay.
module activation_function_unit #(
  parameter int unsigned FRAC_BITS = afu_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_write_en,
  input  logic [1:0]                         cfg_write_data,
  // input words
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [afu_pkg::SAMPLE_W-1:0] in_sample_value,
  input  logic                               in_batch_end,
  // result words
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [afu_pkg::ACT_W-1:0]          out_activation_value,
  output logic                               out_batch_end_out
);

  localparam int unsigned ONE    = 1 << FRAC_BITS;
  localparam int unsigned HALF   = 1 << (FRAC_BITS - 1);
  localparam int unsigned LEVELS = 1 << (FRAC_BITS - 1);
  localparam int unsigned PW     = FRAC_BITS - 1;       // search position width
  localparam int unsigned SW     = FRAC_BITS + 1;       // sigmoid value width
  localparam int unsigned PRODW  = 2 * SW;
  localparam int unsigned NSRCH  = FRAC_BITS - 1;       // binary search stages
  localparam int unsigned SAW    = afu_pkg::SAMPLE_W;
  localparam int unsigned ACW    = afu_pkg::ACT_W;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  afu_pkg::act_mode_t mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= afu_pkg::MODE_RELU;
    end else if (cfg_write_en) begin
      mode_r <= afu_pkg::act_mode_t'(cfg_write_data);
    end
  end

  // ---------------------------------------------------------------------------
  // Sigmoid level thresholds: rounded sigmoid of magnitude m equals
  // HALF + (number of thresholds <= m). Sorted ascending.
  // ---------------------------------------------------------------------------
  afu_pkg::mag_t thr [LEVELS];

  for (genvar gj = 0; gj < LEVELS; gj++) begin : g_thr
    localparam afu_pkg::mag_t THR_VAL = afu_pkg::sig_threshold(FRAC_BITS, gj);
    assign thr[gj] = THR_VAL;
  end

  // ---------------------------------------------------------------------------
  // Global advance: the pipe moves when the output register can take a word.
  // ---------------------------------------------------------------------------
  logic out_valid_r;
  logic advance;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance;

  // ---------------------------------------------------------------------------
  // Stage 0: capture sample, form magnitude. Stages 1..NSRCH: binary search.
  // ---------------------------------------------------------------------------
  logic                  srch_valid_r [NSRCH+1];
  logic signed [SAW-1:0] srch_v_r     [NSRCH+1];
  afu_pkg::mag_t         srch_mag_r   [NSRCH+1];
  logic [PW-1:0]         srch_pos_r   [NSRCH+1];
  logic                  srch_last_r  [NSRCH+1];

  afu_pkg::mag_t mag_nxt;

  assign mag_nxt = in_sample_value[SAW-1] ? afu_pkg::mag_t'(~in_sample_value + 1'b1)
                                          : afu_pkg::mag_t'(in_sample_value);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srch_valid_r[0] <= 1'b0;
    end else if (advance) begin
      srch_valid_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      srch_v_r[0]    <= in_sample_value;
      srch_mag_r[0]  <= mag_nxt;
      srch_pos_r[0]  <= '0;
      srch_last_r[0] <= in_batch_end;
    end
  end

  for (genvar gi = 1; gi <= NSRCH; gi++) begin : g_srch
    localparam int unsigned BIT = NSRCH - gi;
    logic [PW-1:0] probe;
    logic          hit;
    logic [PW-1:0] pos_nxt;

    // probe the last threshold of the lower half of the remaining window
    assign probe   = srch_pos_r[gi-1] + PW'((1 << BIT) - 1);
    assign hit     = srch_mag_r[gi-1] >= thr[probe];
    assign pos_nxt = hit ? (srch_pos_r[gi-1] | PW'(1 << BIT)) : srch_pos_r[gi-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        srch_valid_r[gi] <= 1'b0;
      end else if (advance) begin
        srch_valid_r[gi] <= srch_valid_r[gi-1];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        srch_v_r[gi]    <= srch_v_r[gi-1];
        srch_mag_r[gi]  <= srch_mag_r[gi-1];
        srch_pos_r[gi]  <= pos_nxt;
        srch_last_r[gi] <= srch_last_r[gi-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Level stage: finish count, fold the sign, form ReLU terms.
  // ---------------------------------------------------------------------------
  logic           lvl_valid_r;
  logic [SW-1:0]  lvl_sig_r;
  logic [ACW-1:0] lvl_relu_r;
  logic           lvl_pos_r;
  logic           lvl_last_r;

  logic           top_hit;
  logic [SW-1:0]  sig_pos;
  logic [SW-1:0]  sig_nxt;
  logic           is_pos;
  logic [ACW-1:0] relu_nxt;

  // the search tops out at LEVELS-1; the last threshold adds the final level
  assign top_hit  = (srch_pos_r[NSRCH] == PW'(LEVELS - 1)) &&
                    (srch_mag_r[NSRCH] >= thr[LEVELS-1]);
  assign sig_pos  = SW'(HALF) + SW'(srch_pos_r[NSRCH]) + SW'(top_hit);
  assign sig_nxt  = srch_v_r[NSRCH][SAW-1] ? (SW'(ONE) - sig_pos) : sig_pos;
  assign is_pos   = !srch_v_r[NSRCH][SAW-1] && (srch_v_r[NSRCH] != '0);
  assign relu_nxt = is_pos ? srch_v_r[NSRCH][ACW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_valid_r <= 1'b0;
    end else if (advance) begin
      lvl_valid_r <= srch_valid_r[NSRCH];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lvl_sig_r  <= sig_nxt;
      lvl_relu_r <= relu_nxt;
      lvl_pos_r  <= is_pos;
      lvl_last_r <= srch_last_r[NSRCH];
    end
  end

  // ---------------------------------------------------------------------------
  // Multiply stage: round(s * (ONE - s) / ONE), ties up.
  // ---------------------------------------------------------------------------
  logic           mul_valid_r;
  logic [SW-1:0]  mul_deriv_r;
  logic [SW-1:0]  mul_sig_r;
  logic [ACW-1:0] mul_relu_r;
  logic           mul_pos_r;
  logic           mul_last_r;

  logic [PRODW-1:0] prod;
  logic [SW-1:0]    deriv_nxt;

  assign prod      = PRODW'(lvl_sig_r) * PRODW'(SW'(ONE) - lvl_sig_r) + PRODW'(HALF);
  assign deriv_nxt = prod[FRAC_BITS +: SW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else if (advance) begin
      mul_valid_r <= lvl_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mul_deriv_r <= deriv_nxt;
      mul_sig_r   <= lvl_sig_r;
      mul_relu_r  <= lvl_relu_r;
      mul_pos_r   <= lvl_pos_r;
      mul_last_r  <= lvl_last_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: select by mode, hold while stalled.
  // ---------------------------------------------------------------------------
  logic [ACW-1:0] act_nxt;
  logic [ACW-1:0] act_r;
  logic           last_r;

  always_comb begin
    case (mode_r)
      afu_pkg::MODE_RELU:          act_nxt = mul_relu_r;
      afu_pkg::MODE_RELU_DERIV:    act_nxt = mul_pos_r ? ACW'(ONE) : '0;
      afu_pkg::MODE_SIGMOID:       act_nxt = ACW'(mul_sig_r);
      afu_pkg::MODE_SIGMOID_DERIV: act_nxt = ACW'(mul_deriv_r);
      default:                     act_nxt = mul_relu_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      act_r  <= act_nxt;
      last_r <= mul_last_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_activation_value = act_r;
  assign out_batch_end_out    = last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_sig_range: assert property (@(posedge clk) disable iff (!rst_n)
    lvl_valid_r |-> (lvl_sig_r <= SW'(ONE)))
    else $error("sigmoid level above one");

  a_sig_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (lvl_valid_r && lvl_pos_r) |-> (lvl_sig_r >= SW'(HALF)))
    else $error("sigmoid of positive sample below one half");

  a_deriv_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mul_valid_r |-> (mul_deriv_r <= SW'(ONE >> 2)))
    else $error("sigmoid derivative above one quarter");

endmodule
